>>> sv/ndd_pkg.sv
// Package for the numeric digit display updater.
// Holds field widths, character codes, register indexes, divide constants
// and the binary to BCD table. No dependencies.
package ndd_pkg;

  localparam int VALUE_W       = 20;
  localparam int CODE_W        = 7;
  localparam int SLOT_W        = 3;
  localparam int NUM_SLOTS     = 7;
  localparam int NUM_DIGITS    = 6;
  localparam int INT_DIGITS_W  = 3;
  localparam int FRAC_DIGITS_W = 2;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 3;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 20'd999999;

  localparam logic [CODE_W-1:0] CODE_ZERO  = 7'h30;
  localparam logic [CODE_W-1:0] CODE_DASH  = 7'h2D;
  localparam logic [CODE_W-1:0] CODE_SPACE = 7'h20;

  localparam logic [INT_DIGITS_W-1:0]  INT_DIGITS_MAX    = 3'd4;
  localparam logic [FRAC_DIGITS_W-1:0] FRAC_DIGITS_MAX   = 2'd2;
  localparam logic [INT_DIGITS_W-1:0]  INT_DIGITS_RESET  = 3'd4;
  localparam logic [FRAC_DIGITS_W-1:0] FRAC_DIGITS_RESET = 2'd2;

  // floor(v / 100) = (v * DIV100_MUL) >> DIV100_SHIFT, exact for v <= 999999.
  localparam logic [20:0] DIV100_MUL   = 21'd1342178;
  localparam int          DIV100_SHIFT = 27;
  // floor(q / 100) = (q * Q_DIV100_MUL) >> Q_DIV100_SHIFT, exact for q <= 9999.
  localparam logic [13:0] Q_DIV100_MUL   = 14'd10486;
  localparam int          Q_DIV100_SHIFT = 20;
  localparam logic [6:0]  RADIX_100      = 7'd100;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INTEGER_DIGITS  = 2'd0,
    CFG_FRACTION_DIGITS = 2'd1
  } cfg_reg_t;

  typedef logic [3:0]        digit_t;
  typedef logic [CODE_W-1:0] code_t;

  // Digit 0 is the thousands digit, digit 5 the hundredths digit.
  typedef struct packed {
    digit_t [NUM_DIGITS-1:0] digits;
    logic                    invalid;
  } digit_word_t;

  typedef logic [7:0] bcd_tab_t [128];

  // Two-digit BCD of 0..99, tens in the upper nibble. Built by counting.
  function automatic bcd_tab_t build_bcd_tab();
    bcd_tab_t tab;
    logic [3:0] tens;
    logic [3:0] ones;
    tens = 4'd0;
    ones = 4'd0;
    for (int i = 0; i < 128; i++) begin
      tab[i] = {tens, ones};
      if (ones == 4'd9) begin
        ones = 4'd0;
        tens = tens + 4'd1;
      end else begin
        ones = ones + 4'd1;
      end
    end
    return tab;
  endfunction

  localparam bcd_tab_t BCD_TAB = build_bcd_tab();

endpackage

>>> sv/numeric_digit_display_updater.sv
// Top level of the numeric digit display updater.
// Holds the configuration registers and joins ndd_bcd and ndd_draw; uses ndd_pkg.

// A reading in hundredths is saturated to 999999, split into six decimal
// digits in a five-stage pipeline, and compared slot by slot against the
// codes already on the display; every slot that changes yields one draw
// word, lowest slot first, with last set on the final word of the reading.
// A reading is accepted every cycle while the draw stage is free; each
// reading then holds the draw stage until its N draw words (N from 0 to 6)
// have all left, since the single output register sends one word a cycle
// while out_ready is high. Configuration writes are taken at any time
// (cfg_ready is always high) and should be made while the block is idle.
module numeric_digit_display_updater (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ndd_pkg::VALUE_W-1:0]     in_value_hundredths,
  input  logic                            in_invalid,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ndd_pkg::SLOT_W-1:0]      out_slot,
  output logic [ndd_pkg::CODE_W-1:0]      out_new_char,
  output logic [ndd_pkg::CODE_W-1:0]      out_old_char,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ndd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ndd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ndd_pkg::*;

  logic [INT_DIGITS_W-1:0]  int_digits_r;
  logic [FRAC_DIGITS_W-1:0] frac_digits_r;

  logic        dig_valid;
  logic        dig_ready;
  digit_word_t dig_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_digits_r  <= INT_DIGITS_RESET;
      frac_digits_r <= FRAC_DIGITS_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_INTEGER_DIGITS) begin
        int_digits_r <= cfg_data;
      end else if (cfg_index == CFG_FRACTION_DIGITS) begin
        frac_digits_r <= cfg_data[FRAC_DIGITS_W-1:0];
      end
    end
  end

  ndd_bcd u_bcd (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value_hundredths),
    .in_invalid (in_invalid),
    .out_valid  (dig_valid),
    .out_ready  (dig_ready),
    .out_word   (dig_word)
  );

  ndd_draw u_draw (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (dig_valid),
    .in_ready     (dig_ready),
    .in_word      (dig_word),
    .int_digits   (int_digits_r),
    .frac_digits  (frac_digits_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_slot     (out_slot),
    .out_new_char (out_new_char),
    .out_old_char (out_old_char),
    .out_last     (out_last)
  );

endmodule

>>> sv/ndd_bcd.sv
// Binary to decimal digit pipeline of the display updater.
// Saturates the reading and splits it into six BCD digits; uses ndd_pkg.
module ndd_bcd (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ndd_pkg::VALUE_W-1:0] in_value,
  input  logic                        in_invalid,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ndd_pkg::digit_word_t        out_word
);
  import ndd_pkg::*;

  logic [4:0] vld_r;
  logic       adv;

  logic [VALUE_W-1:0] v1_r;
  logic               bad1_r;
  logic [VALUE_W-1:0] v2_r;
  logic [13:0]        q2_r;
  logic               bad2_r;
  logic [13:0]        q3_r;
  logic [6:0]         f3_r;
  logic [6:0]         p3_r;
  logic               bad3_r;
  logic [6:0]         f4_r;
  logic [6:0]         p4_r;
  logic [6:0]         m4_r;
  logic               bad4_r;
  digit_word_t        word5_r;

  logic [40:0]        prod1;
  logic [27:0]        prod2;
  logic [VALUE_W-1:0] rem1;
  logic [13:0]        rem2;
  logic [7:0]         bcd_p;
  logic [7:0]         bcd_m;
  logic [7:0]         bcd_f;

  // The whole pipe moves together whenever the last stage is empty or taken.
  assign adv       = !vld_r[4] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[4];
  assign out_word  = word5_r;

  always_comb begin
    prod1 = 41'(v1_r) * 41'(DIV100_MUL);
    rem1  = v2_r - 20'(q2_r) * 20'(RADIX_100);
    prod2 = 28'(q2_r) * 28'(Q_DIV100_MUL);
    rem2  = q3_r - 14'(p3_r) * 14'(RADIX_100);
    bcd_p = BCD_TAB[p4_r];
    bcd_m = BCD_TAB[m4_r];
    bcd_f = BCD_TAB[f4_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v1_r   <= (in_value > VALUE_MAX) ? VALUE_MAX : in_value;
      bad1_r <= in_invalid;

      v2_r   <= v1_r;
      q2_r   <= prod1[DIV100_SHIFT+13:DIV100_SHIFT];
      bad2_r <= bad1_r;

      q3_r   <= q2_r;
      f3_r   <= rem1[6:0];
      p3_r   <= prod2[Q_DIV100_SHIFT+6:Q_DIV100_SHIFT];
      bad3_r <= bad2_r;

      f4_r   <= f3_r;
      p4_r   <= p3_r;
      m4_r   <= rem2[6:0];
      bad4_r <= bad3_r;

      word5_r.digits[0] <= bcd_p[7:4];
      word5_r.digits[1] <= bcd_p[3:0];
      word5_r.digits[2] <= bcd_m[7:4];
      word5_r.digits[3] <= bcd_m[3:0];
      word5_r.digits[4] <= bcd_f[7:4];
      word5_r.digits[5] <= bcd_f[3:0];
      word5_r.invalid   <= bad4_r;
    end
  end

endmodule

>>> sv/ndd_draw.sv
// Draw stage of the display updater: per-slot codes, stored codes and the
// draw command serializer with its output register; uses ndd_pkg.
module ndd_draw (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ndd_pkg::digit_word_t              in_word,
  input  logic [ndd_pkg::INT_DIGITS_W-1:0]  int_digits,
  input  logic [ndd_pkg::FRAC_DIGITS_W-1:0] frac_digits,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ndd_pkg::SLOT_W-1:0]        out_slot,
  output logic [ndd_pkg::CODE_W-1:0]        out_new_char,
  output logic [ndd_pkg::CODE_W-1:0]        out_old_char,
  output logic                              out_last
);
  import ndd_pkg::*;

  code_t                shown_r [NUM_SLOTS];
  code_t                new_r   [NUM_SLOTS];
  code_t                old_r   [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] pend_r;

  logic              out_vld_r;
  logic [SLOT_W-1:0] out_slot_r;
  code_t             out_new_r;
  code_t             out_old_r;
  logic              out_last_r;

  logic [INT_DIGITS_W-1:0]  nint;
  logic [FRAC_DIGITS_W-1:0] nfrac;
  code_t                    code  [NUM_SLOTS];
  code_t                    chr   [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]     show;
  logic [NUM_SLOTS-1:0]     diff;
  logic [SLOT_W-1:0]        sel;
  logic [NUM_SLOTS-1:0]     rest;
  logic                     pop;
  logic                     load;

  always_comb begin
    logic [3:0] s4;
    logic [3:0] nint4;
    logic       is_int;
    logic       is_frac;
    logic [2:0] dsel;
    digit_t     dig;
    logic       seen;
    nint  = (int_digits > INT_DIGITS_MAX) ? INT_DIGITS_MAX : int_digits;
    nfrac = (frac_digits > FRAC_DIGITS_MAX) ? FRAC_DIGITS_MAX : frac_digits;
    nint4 = {1'b0, nint};
    seen  = 1'b0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      s4      = 4'(s);
      is_int  = s4 < nint4;
      // The slot right after the integer digits holds the decimal point.
      is_frac = (nfrac != '0) && (s4 > nint4) && (s4 <= nint4 + {2'b00, nfrac});
      dsel    = is_int ? 3'(4'd4 - nint4 + s4) : 3'(s4 - nint4 + 4'd3);
      dig     = (dsel <= 3'd5) ? in_word.digits[dsel] : '0;
      code[s] = in_word.invalid ? CODE_DASH : CODE_ZERO + 7'(dig);
      chr[s]  = code[s];
      if (is_int) begin
        if (code[s] == CODE_ZERO && !seen) begin
          chr[s] = CODE_SPACE;
        end
        if (code[s] != CODE_ZERO) begin
          seen = 1'b1;
        end
      end
      show[s] = is_int || is_frac;
      diff[s] = show[s] && (shown_r[s] != code[s]);
    end
  end

  // Lowest pending slot goes out first.
  always_comb begin
    sel = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (pend_r[s]) begin
        sel = SLOT_W'(s);
      end
    end
    rest = pend_r & ~(NUM_SLOTS'(1) << sel);
  end

  assign pop      = (pend_r != '0) && (!out_vld_r || out_ready);
  assign in_ready = (pend_r == '0) || (pop && rest == '0);
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      out_vld_r <= 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        shown_r[s] <= '0;
      end
    end else begin
      if (load) begin
        pend_r <= diff;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (show[s]) begin
            shown_r[s] <= code[s];
          end
        end
      end else if (pop) begin
        pend_r <= rest;
      end
      if (pop) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        new_r[s] <= chr[s];
        old_r[s] <= shown_r[s];
      end
    end
    if (pop) begin
      out_slot_r <= sel;
      out_new_r  <= new_r[sel];
      out_old_r  <= old_r[sel];
      out_last_r <= (rest == '0);
    end
  end

  assign out_valid    = out_vld_r;
  assign out_slot     = out_slot_r;
  assign out_new_char = out_new_r;
  assign out_old_char = out_old_r;
  assign out_last     = out_last_r;

endmodule

>>> sv/ndd_checker.sv
// Port-level checks for the numeric digit display updater, bound to the top.
// Uses only the top level's ports; depends on ndd_pkg.
module ndd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ndd_pkg::SLOT_W-1:0] out_slot,
  input logic [ndd_pkg::CODE_W-1:0] out_new_char,
  input logic [ndd_pkg::CODE_W-1:0] out_old_char,
  input logic                       out_last
);
  import ndd_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("draw word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) &&
      $stable(out_new_char) && $stable(out_old_char) && $stable(out_last))
    else $error("stalled draw word changed");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_new_char >= CODE_ZERO && out_new_char <= 7'h39) ||
      out_new_char == CODE_SPACE || out_new_char == CODE_DASH)
    else $error("draw character is not a digit, space or dash");

  a_char_changes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_new_char != out_old_char)
    else $error("draw word does not change the slot");

  // Words of one reading follow each other without a gap, slots rising.
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_slot > $past(out_slot))
    else $error("draw words of one reading out of slot order");

endmodule

bind numeric_digit_display_updater ndd_checker u_ndd_checker (.*);
